// File: rtl/core/euclidean_distance_stream_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the euclidean distance stream checker.
// ---------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_STREAM_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_STREAM_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define ED_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Implication under the same clock and reset.
`define ED_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ed_pkg.sv
// ---------------------------------------------------------------------------
// ed_pkg
// Shared widths and types for the euclidean distance stream.
// ---------------------------------------------------------------------------
package ed_pkg;

	localparam int COORD_BITS = 16;
	localparam int SUM_BITS   = 39;
	localparam int DIST_BITS  = 20;
	localparam int SQRT_STEPS = (SUM_BITS + 1) / 2;
	localparam int RAD_BITS   = 2 * SQRT_STEPS;
	localparam int REM_BITS   = DIST_BITS + 3;
	localparam int STEP_BITS  = $clog2(SQRT_STEPS);
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int DIN_BITS   = 2 * COORD_BITS;
	localparam int DOUT_BITS  = ((DIST_BITS + 7) / 8) * 8;

	typedef logic [SUM_BITS-1:0] sum_t;

	// Queue status seen by the writer and the reader
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: rtl/core/ed_front.sv
// ---------------------------------------------------------------------------
// ed_front
// Accepts coordinate pairs, squares the difference and accumulates the
// saturating sum of squares; pushes the finished sum on the last element.
// ---------------------------------------------------------------------------
module ed_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ed_pkg::COORD_BITS-1:0] coord_a,
	input  logic [ed_pkg::COORD_BITS-1:0] coord_b,
	input  logic                          last_element,
	input  ed_pkg::q_stat_t               q_stat,
	output logic                          push,
	output ed_pkg::sum_t                  push_data
);
	import ed_pkg::*;

	logic                      advance;
	logic                      v_s1, v_s2;
	logic                      last_s1, last_s2;
	logic [COORD_BITS-1:0]     diff_s1;
	logic [2*COORD_BITS-1:0]   sq_s2;
	sum_t                      acc_q;
	logic [SUM_BITS:0]         sum_w;
	sum_t                      sum_sat;

	// Whole front stalls only when a finished sum meets a full queue
	assign advance  = !(v_s2 && last_s2 && q_stat.full);
	assign in_ready = advance;

	// Saturating accumulate
	assign sum_w   = {1'b0, acc_q} + (SUM_BITS+1)'(sq_s2);
	assign sum_sat = sum_w[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_w[SUM_BITS-1:0];

	assign push      = advance && v_s2 && last_s2;
	assign push_data = sum_sat;

	// Valid bits and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			if (v_s2) begin
				acc_q <= last_s2 ? '0 : sum_sat;
			end
		end
	end

	// Absolute difference, then square
	always_ff @(posedge clk) begin
		if (advance) begin
			diff_s1 <= (coord_a >= coord_b) ? (coord_a - coord_b) : (coord_b - coord_a);
			last_s1 <= last_element;
			sq_s2   <= diff_s1 * diff_s1;
			last_s2 <= last_s1;
		end
	end

endmodule

// File: rtl/core/ed_fifo.sv
// ---------------------------------------------------------------------------
// ed_fifo
// Short queue of finished sums between the front and the square root unit.
// ---------------------------------------------------------------------------
module ed_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ed_pkg::sum_t    push_data,
	input  logic            pop,
	output ed_pkg::sum_t    pop_data,
	output ed_pkg::q_stat_t stat
);
	import ed_pkg::*;

	sum_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   count_q;

	assign stat.full  = (count_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: rtl/core/ed_sqrt.sv
// ---------------------------------------------------------------------------
// ed_sqrt
// Back end: digit-by-digit floor square root, one result bit per cycle,
// with an output register on the master side.
// ---------------------------------------------------------------------------
module ed_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ed_pkg::q_stat_t              q_stat,
	input  ed_pkg::sum_t                 pop_data,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ed_pkg::DIST_BITS-1:0] distance
);
	import ed_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [RAD_BITS-1:0]   rad_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [DIST_BITS-1:0]  root_q;
	logic [REM_BITS-1:0]   cand;
	logic [REM_BITS-1:0]   trial;
	logic                  ge;
	logic                  load_out;
	logic                  out_valid_q;
	logic [DIST_BITS-1:0]  dist_q;

	// One root bit: bring down two radicand bits, try root*4+1
	assign cand  = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (cand >= trial);

	assign pop       = (state_q == ST_IDLE) && !q_stat.empty;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign distance  = dist_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_CALC;
						step_q  <= STEP_BITS'(SQRT_STEPS - 1);
					end
				end
				ST_CALC: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			rad_q  <= RAD_BITS'(pop_data);
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == ST_CALC) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			rem_q  <= ge ? (cand - trial) : cand;
			root_q <= {root_q[DIST_BITS-2:0], ge};
		end
		if (load_out) begin
			dist_q <= root_q;
		end
	end

endmodule

// File: rtl/core/euclidean_distance_stream.sv
// ---------------------------------------------------------------------------
// euclidean_distance_stream
// Streaming Euclidean distance between two points in unsigned Q0.16.
// ---------------------------------------------------------------------------
// Slave side carries one component pair per word: coord_a in s_tdata[15:0],
// coord_b in s_tdata[31:16]; s_tlast marks the last component of a vector.
// Each pair's squared difference is added to a saturating 39-bit sum
// (LSB 2^-32). On the last word the sum goes to a four-entry queue and is
// cleared for the next vector.
// Master side returns one word per vector: m_tdata[19:0] is the floor square
// root of the sum (LSB 2^-16), upper bits zero.
// Input accepts one word per cycle unless a finished sum meets a full queue.
// The square root unit resolves one result bit per cycle and holds one
// vector at a time (pop, 20 steps, hand-off); short vectors are absorbed
// by the queue and then back-pressure s_tready.
// Reset clears the sum, the queue and all valid flags; s_tready is high
// right after reset. A stalled m_tready holds the result in the output
// register and, once the queue fills, stalls the slave side.
// ---------------------------------------------------------------------------
module euclidean_distance_stream (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ed_pkg::DIN_BITS-1:0]  s_tdata,  // coord_a, coord_b
	input  logic                         s_tlast,  // last_element
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ed_pkg::DOUT_BITS-1:0] m_tdata   // distance, zero pad
);
	import ed_pkg::*;

	q_stat_t              q_stat;
	logic                 push, pop;
	sum_t                 push_data, pop_data;
	logic [DIST_BITS-1:0] distance;

	// Front: difference, square, accumulate
	ed_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.coord_a      (s_tdata[COORD_BITS-1:0]),
		.coord_b      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.last_element (s_tlast),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	// Queue of finished sums
	ed_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// Back: square root and output register
	ed_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.distance  (distance)
	);

	assign m_tdata = DOUT_BITS'(distance);

endmodule

// File: rtl/core/ed_checker.sv
// ---------------------------------------------------------------------------
// ed_checker
// Port-level checks on the euclidean distance stream, bound to the top.
// ---------------------------------------------------------------------------
`include "euclidean_distance_stream_assert.svh"

module ed_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic                         s_tlast,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [ed_pkg::DOUT_BITS-1:0] m_tdata
);
	logic [3:0] pend_q;
	logic       in_last, out_word;

	assign in_last  = s_tvalid && s_tready && s_tlast;
	assign out_word = m_tvalid && m_tready;

	// Vectors closed on the slave side and not yet returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_last, out_word})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	`ED_ASSERT_IMP(a_out_hold, clk, arst_n, m_tvalid && !m_tready ##1 1'b1, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`ED_ASSERT_IMP(a_no_extra, clk, arst_n, m_tvalid, pend_q != 4'd0, "result without a closed vector")
	`ED_ASSERT_IMP(a_stall_cause, clk, arst_n, !s_tready, pend_q >= 4'd5, "slave stalled with room to spare")
	`ED_ASSERT_CLK(a_pend_bound, clk, arst_n, pend_q <= 4'd8, "more vectors in flight than storage")

endmodule

bind euclidean_distance_stream ed_checker u_ed_checker (.*);

// File: test/euclidean_distance_stream_test.sv
// ---------------------------------------------------------------------------
// euclidean_distance_stream_test
// Self-checking bench for the streaming Euclidean distance block. Words of
// coordinate pairs go in on the slave side with random gaps. Each returned
// distance is compared with a running-sum and square-root predictor kept in
// the bench. Directed vectors cover extremes and saturation, then random
// vectors follow. The master side stalls at random, with one long hold-off.
// ---------------------------------------------------------------------------
module euclidean_distance_stream_test;

	timeunit 1ns;
	timeprecision 1ps;

	import ed_pkg::*;

	localparam int   RAND_WORDS = 100;
	localparam int   MIN_RAND_VECS = 10;
	localparam int   HOLD_CYCLES = 400;
	localparam sum_t SUM_FULL = {SUM_BITS{1'b1}};

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DIST_BITS-1:0]  dist_t;

	// directed stimulus row: one pair repeated reps times, optional known distance
	typedef struct {
		coord_t a;
		coord_t b;
		logic   last;
		int     reps;
		bit     known;
		dist_t  known_dist;
	} pair_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [DIN_BITS-1:0]  s_tdata;   // coord_a, coord_b
	logic                 s_tlast;   // last_element
	logic                 m_tvalid;
	logic                 m_tready;
	logic [DOUT_BITS-1:0] m_tdata;   // distance, zero pad

	// bench state
	sum_t  vec_sum;
	bit    vec_saturated;
	dist_t dist_due [$];
	int    errors;
	int    words_sent;
	int    vectors_sent;
	int    dists_checked;
	int    saturated_vecs;
	bit    hold_req;
	bit    calm;

	pair_row_t directed_rows [22] = '{
		'{16'h0000, 16'h0000, 1'b1, 1, 1'b1, 20'd0},
		'{16'hFFFF, 16'h0000, 1'b1, 1, 1'b1, 20'd65535},
		'{16'h0000, 16'hFFFF, 1'b1, 1, 1'b1, 20'd65535},
		'{16'hFFFF, 16'hFFFF, 1'b1, 1, 1'b1, 20'd0},
		'{16'h0001, 16'h0000, 1'b1, 1, 1'b1, 20'd1},
		'{16'h8000, 16'h7FFF, 1'b1, 1, 1'b1, 20'd1},
		'{16'hAAAA, 16'h5555, 1'b1, 1, 1'b1, 20'd21845},
		'{16'h5555, 16'hAAAA, 1'b1, 1, 1'b1, 20'd21845},
		'{16'h0003, 16'h0000, 1'b0, 1, 1'b0, 20'd0},
		'{16'h0000, 16'h0004, 1'b1, 1, 1'b1, 20'd5},
		'{16'hFFFF, 16'h0000, 1'b0, 1, 1'b0, 20'd0},
		'{16'hFFFF, 16'h0000, 1'b1, 1, 1'b1, 20'd92680},
		'{16'h0000, 16'h0002, 1'b0, 1, 1'b0, 20'd0},
		'{16'h0000, 16'h0001, 1'b1, 1, 1'b1, 20'd2},
		// long full-scale vector drives the sum into saturation
		'{16'h0000, 16'hFFFF, 1'b0, 128, 1'b0, 20'd0},
		'{16'hFFFF, 16'h0000, 1'b1, 1, 1'b1, 20'd741455},
		// sum must start from zero after a saturated vector
		'{16'h0000, 16'h0002, 1'b1, 1, 1'b1, 20'd2},
		// 128 full-scale pairs stay just under the bound
		'{16'hFFFF, 16'h0000, 1'b0, 127, 1'b0, 20'd0},
		'{16'h0000, 16'hFFFF, 1'b1, 1, 1'b0, 20'd0},
		'{16'h1234, 16'hFEDC, 1'b0, 1, 1'b0, 20'd0},
		'{16'h0F0F, 16'hF0F0, 1'b1, 1, 1'b0, 20'd0},
		'{16'h7FFF, 16'h8000, 1'b1, 1, 1'b0, 20'd0}
	};

	euclidean_distance_stream i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// floor square root, one result bit at a time from the top
	function automatic dist_t floor_root(sum_t v);
		logic [2*DIST_BITS-1:0] root;
		logic [2*DIST_BITS-1:0] trial;
		root = '0;
		for (int i = DIST_BITS - 1; i >= 0; i--) begin
			trial = root | ({{(2*DIST_BITS-1){1'b0}}, 1'b1} << i);
			if (trial * trial <= {1'b0, v})
				root = trial;
		end
		return root[DIST_BITS-1:0];
	endfunction

	// adds one pair to the running sum; returns 1 with the distance on the last word
	function automatic bit accumulate_pair(coord_t a, coord_t b, logic last,
			output dist_t root);
		coord_t                 diff;
		logic [2*COORD_BITS-1:0] diff_sq;
		logic [SUM_BITS:0]      wide;
		diff = (a >= b) ? a - b : b - a;
		diff_sq = diff * diff;
		wide = {1'b0, vec_sum} + {{(SUM_BITS+1-2*COORD_BITS){1'b0}}, diff_sq};
		if (wide > {1'b0, SUM_FULL}) begin
			vec_sum = SUM_FULL;
			vec_saturated = 1'b1;
		end else begin
			vec_sum = wide[SUM_BITS-1:0];
		end
		root = '0;
		if (!last)
			return 1'b0;
		root = floor_root(vec_sum);
		if (vec_saturated)
			saturated_vecs++;
		vec_sum = '0;
		vec_saturated = 1'b0;
		return 1'b1;
	endfunction

	// gap length shared by both sides: mostly none or short, a few long
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	// offer one word and wait for it to be taken
	task automatic send_word(coord_t a, coord_t b, logic last, bit known, dist_t known_dist);
		dist_t root;
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (accumulate_pair(a, b, last, root)) begin
			vectors_sent++;
			dist_due.push_back(known ? known_dist : root);
		end
	endtask

	// drop valid for a while, with junk on the data lines
	task automatic sender_idle(int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			s_tlast  <= 1'($urandom_range(0, 1));
			repeat (cycles) @(posedge clk);
		end
	endtask

	// one pair drawn by profile: uniform, extremes, near-equal, full-scale
	task automatic pick_pair(int profile, output coord_t a, output coord_t b);
		coord_t t;
		case (profile)
			0: begin
				a = coord_t'($urandom);
				b = coord_t'($urandom);
			end
			1: begin
				a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
				b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			end
			2: begin
				a = coord_t'($urandom);
				b = a + coord_t'($urandom_range(0, 8)) - coord_t'(4);
			end
			default: begin
				a = coord_t'($urandom_range(0, 15));
				b = coord_t'($urandom_range(16'hFFF0, 16'hFFFF));
			end
		endcase
		if ($urandom_range(0, 1)) begin
			t = a;
			a = b;
			b = t;
		end
	endtask

	task automatic send_vector(int len, int profile);
		coord_t a;
		coord_t b;
		for (int i = 0; i < len; i++) begin
			pick_pair(profile, a, b);
			send_word(a, b, i == len - 1, 1'b0, '0);
			sender_idle(gap_len());
		end
	endtask

	// result check
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_due.size() == 0) begin
				$display("%0t: unexpected distance word, expected none, got %0d",
					$time, m_tdata);
				errors++;
			end else begin
				if (m_tdata !== {{(DOUT_BITS-DIST_BITS){1'b0}}, dist_due[0]}) begin
					$display("%0t: distance mismatch, expected %0d, got %0d",
						$time, dist_due[0], m_tdata);
					errors++;
				end
				void'(dist_due.pop_front());
				dists_checked++;
			end
		end
	end

	// master-side back-pressure, with one long hold-off on request
	initial begin
		int run;
		int stall;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			run = calm ? 8 : $urandom_range(1, 12);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = gap_len();
			if (!hold_req && stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Run limit reached with %0d distances outstanding", dist_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// reset, stimulus and verdict
	initial begin
		int     vec_idx;
		int     dir_words;
		int     r;
		coord_t a;
		coord_t b;
		errors = 0;
		words_sent = 0;
		vectors_sent = 0;
		dists_checked = 0;
		saturated_vecs = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		vec_sum = '0;
		vec_saturated = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (directed_rows[i]) begin
			for (int k = 0; k < directed_rows[i].reps; k++) begin
				send_word(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
					directed_rows[i].known, directed_rows[i].known_dist);
				sender_idle(gap_len());
			end
		end
		dir_words = words_sent;

		// random vectors
		vec_idx = 0;
		while (words_sent - dir_words < RAND_WORDS || vec_idx < MIN_RAND_VECS) begin
			calm = (vec_idx >= 6 && vec_idx < 9);
			if (vec_idx == 2) begin
				// burst of one-word vectors into a held-off master side
				hold_req = 1'b1;
				for (int k = 0; k < 30; k++) begin
					a = coord_t'($urandom);
					b = coord_t'($urandom);
					send_word(a, b, 1'b1, 1'b0, '0);
				end
			end
			if (vec_idx == 5) begin
				// sender waits for the pipeline to drain completely
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (dist_due.size() != 0) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 65)
				send_vector($urandom_range(1, 8), $urandom_range(0, 2));
			else if (r < 85)
				send_vector($urandom_range(9, 40), $urandom_range(0, 3));
			else if (r < 98)
				send_vector(1, $urandom_range(0, 3));
			else
				send_vector($urandom_range(130, 140), 3);
			vec_idx++;
		end

		// drain
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (dist_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d words in %0d vectors (%0d saturated), %0d distances checked",
			words_sent, vectors_sent, saturated_vecs, dists_checked);
		$display("Included a long master hold-off, a full drain pause and %0d mismatches",
			errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ed_pkg.sv
rtl/core/ed_front.sv
rtl/core/ed_fifo.sv
rtl/core/ed_sqrt.sv
rtl/core/euclidean_distance_stream.sv
rtl/core/ed_checker.sv
test/euclidean_distance_stream_test.sv
